// ===== src/box_similarity_score_assert.svh =====
// Assertion macros shared by the box similarity RTL.
// No dependencies; included by box_similarity_score, the module that carries checks.
`ifndef BOX_SIMILARITY_SCORE_ASSERT_SVH
`define BOX_SIMILARITY_SCORE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define BSS_CHECK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bss check failed");

// Next-cycle implication, active through reset.
`define BSS_CHECK_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bss check failed");

`endif

// ===== src/bss_pkg.sv =====
// Shared types and constants for the box similarity score pipeline.
// No dependencies.
package bss_pkg;

   // weights of 0.5 / 0.3 / 0.2 scaled by ten
   localparam int unsigned IOU_WEIGHT     = 5;
   localparam int unsigned SHAPE_WEIGHT   = 3;
   localparam int unsigned DIS_WEIGHT     = 2;
   // divide by ten done as halve, then divide by five
   localparam int unsigned SCORE_HALF_DIV = 5;

   typedef struct packed {
      logic valid;
      logic degenerate;
   } pipe_ctrl_type;

endpackage

// ===== src/bss_div.sv =====
// Pipelined restoring fraction divider, one quotient bit per stage.
// Depends on nothing; quotient = floor(2^(QUOT_W-1) * num / den) for num <= den.
module bss_div #(
   parameter int DATA_W = 16,
   parameter int QUOT_W = 17
) (
   input  logic              clock,
   input  logic              en,
   input  logic [DATA_W-1:0] num,
   input  logic [DATA_W-1:0] den,
   output logic [QUOT_W-1:0] quot
);

   logic [DATA_W-1:0] rem_ff [QUOT_W];
   logic [DATA_W-1:0] den_ff [QUOT_W];
   logic [QUOT_W-1:0] q_ff   [QUOT_W];

   for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
      logic [DATA_W:0]   trial;
      logic [DATA_W-1:0] d_cur;
      logic [QUOT_W-1:0] q_prev;
      logic              ge;
      logic [DATA_W-1:0] rem_in;
      logic [QUOT_W-1:0] q_in;

      if (i == 0) begin : g_first
         assign trial  = {1'b0, num};
         assign d_cur  = den;
         assign q_prev = '0;
      end else begin : g_next
         assign trial  = {rem_ff[i-1], 1'b0};
         assign d_cur  = den_ff[i-1];
         assign q_prev = q_ff[i-1];
      end

      always_comb begin
         logic [DATA_W:0] diff;
         diff   = trial - {1'b0, d_cur};
         ge     = (trial >= {1'b0, d_cur});
         rem_in = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         q_in   = {q_prev[QUOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= d_cur;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign quot = q_ff[QUOT_W-1];

endmodule

// ===== src/bss_front.sv =====
// Geometry front end: enclosing box, overlap, areas and the three
// numerator/denominator pairs, over four register stages. Uses bss_pkg.
module bss_front import bss_pkg::*; #(
   parameter int COORD_BITS = 12,
   localparam int C      = COORD_BITS,
   localparam int IOU_W  = 2*C + 1,
   localparam int SH_W   = 4*C + 5,
   localparam int DIS_W  = 2*C + 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [C-1:0]    ref_x,
   input  logic [C-1:0]    ref_y,
   input  logic [C-1:0]    ref_w,
   input  logic [C-1:0]    ref_h,
   input  logic [C-1:0]    cand_x,
   input  logic [C-1:0]    cand_y,
   input  logic [C-1:0]    cand_w,
   input  logic [C-1:0]    cand_h,
   output pipe_ctrl_type   ctrl_out,
   output logic [IOU_W-1:0] iou_num,
   output logic [IOU_W-1:0] iou_den,
   output logic [SH_W-1:0]  sh_num,
   output logic [SH_W-1:0]  sh_den,
   output logic [DIS_W-1:0] dis_num,
   output logic [DIS_W-1:0] dis_den
);

   localparam int EW  = C + 1;
   localparam int DIW = C + 2;

   pipe_ctrl_type ctrl1_ff, ctrl2_ff, ctrl3_ff, ctrl4_ff;

   // stage 1: extents and differences
   logic [C-1:0]   w1_ff, h1_ff, w2_ff, h2_ff, ox_ff, oy_ff, dw_ff, dh_ff;
   logic [EW-1:0]  bw_ff, bh_ff;
   logic [DIW-1:0] dcx_ff, dcy_ff;
   logic [C-1:0]   ox_in, oy_in, dw_in, dh_in;
   logic [EW-1:0]  bw_in, bh_in;
   logic [DIW-1:0] dcx_in, dcy_in;

   always_comb begin
      logic [EW-1:0]  xa, xb, ya, yb, xea, xeb, yea, yeb, lo, hi, mn, mx;
      logic [DIW-1:0] sa, sb;
      xa  = {1'b0, ref_x};
      xb  = {1'b0, cand_x};
      ya  = {1'b0, ref_y};
      yb  = {1'b0, cand_y};
      xea = xa + {1'b0, ref_w};
      xeb = xb + {1'b0, cand_w};
      yea = ya + {1'b0, ref_h};
      yeb = yb + {1'b0, cand_h};

      mx    = (xea > xeb) ? xea : xeb;
      mn    = (xa < xb) ? xa : xb;
      bw_in = mx - mn;
      mx    = (yea > yeb) ? yea : yeb;
      mn    = (ya < yb) ? ya : yb;
      bh_in = mx - mn;

      hi    = (xea < xeb) ? xea : xeb;
      lo    = (xa > xb) ? xa : xb;
      ox_in = (hi > lo) ? C'(hi - lo) : '0;
      hi    = (yea < yeb) ? yea : yeb;
      lo    = (ya > yb) ? ya : yb;
      oy_in = (hi > lo) ? C'(hi - lo) : '0;

      dw_in = (ref_w > cand_w) ? ref_w - cand_w : cand_w - ref_w;
      dh_in = (ref_h > cand_h) ? ref_h - cand_h : cand_h - ref_h;

      // doubled centres
      sa     = {1'b0, xa} + {1'b0, xea};
      sb     = {1'b0, xb} + {1'b0, xeb};
      dcx_in = (sa > sb) ? sa - sb : sb - sa;
      sa     = {1'b0, ya} + {1'b0, yea};
      sb     = {1'b0, yb} + {1'b0, yeb};
      dcy_in = (sa > sb) ? sa - sb : sb - sa;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff  <= ref_w;
         h1_ff  <= ref_h;
         w2_ff  <= cand_w;
         h2_ff  <= cand_h;
         bw_ff  <= bw_in;
         bh_ff  <= bh_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         dw_ff  <= dw_in;
         dh_ff  <= dh_in;
         dcx_ff <= dcx_in;
         dcy_ff <= dcy_in;
      end
   end

   // stage 2: products
   logic [2*C-1:0]   inter_ff, a1_ff, a2_ff;
   logic [C+EW-1:0]  dwh_ff, dhw_ff;
   logic [2*EW-1:0]  wh_ff, wsq_ff, hsq_ff;
   logic [2*DIW-1:0] dcxsq_ff, dcysq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         inter_ff <= {{C{1'b0}}, ox_ff} * {{C{1'b0}}, oy_ff};
         a1_ff    <= {{C{1'b0}}, w1_ff} * {{C{1'b0}}, h1_ff};
         a2_ff    <= {{C{1'b0}}, w2_ff} * {{C{1'b0}}, h2_ff};
         dwh_ff   <= {{EW{1'b0}}, dw_ff} * {{C{1'b0}}, bh_ff};
         dhw_ff   <= {{EW{1'b0}}, dh_ff} * {{C{1'b0}}, bw_ff};
         wh_ff    <= {{EW{1'b0}}, bw_ff} * {{EW{1'b0}}, bh_ff};
         wsq_ff   <= {{EW{1'b0}}, bw_ff} * {{EW{1'b0}}, bw_ff};
         hsq_ff   <= {{EW{1'b0}}, bh_ff} * {{EW{1'b0}}, bh_ff};
         dcxsq_ff <= {{DIW{1'b0}}, dcx_ff} * {{DIW{1'b0}}, dcx_ff};
         dcysq_ff <= {{DIW{1'b0}}, dcy_ff} * {{DIW{1'b0}}, dcy_ff};
      end
   end

   // stage 3: union, squares, centre terms
   logic [IOU_W-1:0]     iou_num3_ff, iou_den3_ff;
   logic [DIS_W-1:0]     dis_num3_ff, dis_den3_ff;
   logic [2*(C+EW)-1:0]  sqa_ff, sqb_ff;
   logic [4*EW-1:0]      whsq_ff;
   logic [IOU_W-1:0]     uni;

   assign uni = {1'b0, a1_ff} + {1'b0, a2_ff} - {1'b0, inter_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         iou_num3_ff <= {1'b0, inter_ff};
         // empty union only with empty overlap; a unit divisor keeps the quotient zero
         iou_den3_ff <= (uni == '0) ? IOU_W'(1) : uni;
         dis_num3_ff <= DIS_W'({1'b0, dcxsq_ff}) + DIS_W'({1'b0, dcysq_ff});
         dis_den3_ff <= DIS_W'({({1'b0, wsq_ff} + {1'b0, hsq_ff}), 2'b00});
         sqa_ff      <= {{(C+EW){1'b0}}, dwh_ff} * {{(C+EW){1'b0}}, dwh_ff};
         sqb_ff      <= {{(C+EW){1'b0}}, dhw_ff} * {{(C+EW){1'b0}}, dhw_ff};
         whsq_ff     <= {{(2*EW){1'b0}}, wh_ff} * {{(2*EW){1'b0}}, wh_ff};
      end
   end

   // stage 4: shape numerator and denominator
   logic [IOU_W-1:0] iou_num4_ff, iou_den4_ff;
   logic [DIS_W-1:0] dis_num4_ff, dis_den4_ff;
   logic [SH_W-1:0]  sh_num4_ff, sh_den4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         iou_num4_ff <= iou_num3_ff;
         iou_den4_ff <= iou_den3_ff;
         dis_num4_ff <= dis_num3_ff;
         dis_den4_ff <= dis_den3_ff;
         sh_num4_ff  <= SH_W'(sqa_ff) + SH_W'(sqb_ff);
         sh_den4_ff  <= SH_W'({whsq_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
         ctrl4_ff <= '0;
      end else if (en) begin
         ctrl1_ff.valid      <= in_valid;
         ctrl1_ff.degenerate <= (bw_in == '0) || (bh_in == '0);
         ctrl2_ff            <= ctrl1_ff;
         ctrl3_ff            <= ctrl2_ff;
         ctrl4_ff            <= ctrl3_ff;
      end
   end

   assign ctrl_out = ctrl4_ff;
   assign iou_num  = iou_num4_ff;
   assign iou_den  = iou_den4_ff;
   assign sh_num   = sh_num4_ff;
   assign sh_den   = sh_den4_ff;
   assign dis_num  = dis_num4_ff;
   assign dis_den  = dis_den4_ff;

endmodule

// ===== src/bss_combine.sv =====
// Weighted sum of the three ratios and divide by ten, three register stages.
// Uses bss_pkg for weights and the divisor.
module bss_combine import bss_pkg::*; #(
   parameter int FRAC_BITS = 16,
   localparam int F = FRAC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  pipe_ctrl_type ctrl_in,
   input  logic [F:0]    iou_q,
   input  logic [F:0]    sh_q,
   input  logic [F:0]    dis_q,
   output logic          out_valid,
   output logic [F:0]    score,
   output logic          degenerate
);

   localparam int SW          = F + 4;
   localparam int HW          = F + 3;
   localparam int RECIP_SHIFT = F + 5;
   localparam int RW          = RECIP_SHIFT - 2;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / SCORE_HALF_DIV;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   pipe_ctrl_type ctrl_a_ff, ctrl_b_ff;
   logic [HW-1:0]    half_a_ff, half_b_ff;
   logic [HW+RW-1:0] prod_ff;
   logic [SW-1:0]    sum;
   logic [F:0]       q0, q_fix;
   logic [HW-1:0]    rem;
   logic [F:0]       score_ff;
   logic             valid_ff, deg_ff;

   always_comb begin
      sum = SW'(IOU_WEIGHT) * SW'(iou_q)
          + SW'(SHAPE_WEIGHT) * SW'(ONE - sh_q)
          + SW'(DIS_WEIGHT) * SW'(ONE - dis_q);
   end

   // reciprocal estimate is low by at most one
   assign q0    = (F+1)'(prod_ff >> RECIP_SHIFT);
   assign rem   = half_b_ff - HW'(SW'(SCORE_HALF_DIV) * SW'(q0));
   assign q_fix = (rem >= HW'(SCORE_HALF_DIV)) ? q0 + 1'b1 : q0;

   always_ff @(posedge clock) begin
      if (en) begin
         half_a_ff <= sum[SW-1:1];
         half_b_ff <= half_a_ff;
         prod_ff   <= {{RW{1'b0}}, half_a_ff} * {{HW{1'b0}}, RW'(RECIP)};
         score_ff  <= ctrl_b_ff.degenerate ? '0 : q_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
         valid_ff  <= 1'b0;
         deg_ff    <= 1'b0;
      end else if (en) begin
         ctrl_a_ff <= ctrl_in;
         ctrl_b_ff <= ctrl_a_ff;
         valid_ff  <= ctrl_b_ff.valid;
         deg_ff    <= ctrl_b_ff.degenerate;
      end
   end

   assign out_valid  = valid_ff;
   assign score      = score_ff;
   assign degenerate = deg_ff;

endmodule

// ===== src/box_similarity_score.sv =====
// Box similarity score: 0.5 IoU + 0.3 shape + 0.2 centre distance, Q1.FRAC_BITS.
// Four geometry stages, one divider stage per quotient bit and three scoring
// stages. Throughput one request per cycle; the whole pipeline holds while the
// output register waits.
// Synchronous active-high reset empties the pipeline; no clearing pass.
`include "box_similarity_score_assert.svh"
module box_similarity_score import bss_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_ref_x,
   input  logic [COORD_BITS-1:0] req_ref_y,
   input  logic [COORD_BITS-1:0] req_ref_w,
   input  logic [COORD_BITS-1:0] req_ref_h,
   input  logic [COORD_BITS-1:0] req_cand_x,
   input  logic [COORD_BITS-1:0] req_cand_y,
   input  logic [COORD_BITS-1:0] req_cand_w,
   input  logic [COORD_BITS-1:0] req_cand_h,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FRAC_BITS:0]    rsp_score,
   output logic                  rsp_degenerate
);

   localparam int C       = COORD_BITS;
   localparam int IOU_W   = 2*C + 1;
   localparam int SH_W    = 4*C + 5;
   localparam int DIS_W   = 2*C + 5;
   localparam int DIV_LAT = FRAC_BITS + 1;

   logic            en;
   pipe_ctrl_type   front_ctrl;
   pipe_ctrl_type   ctrl_ff [DIV_LAT];
   logic [IOU_W-1:0] iou_num, iou_den;
   logic [SH_W-1:0]  sh_num, sh_den;
   logic [DIS_W-1:0] dis_num, dis_den;
   logic [FRAC_BITS:0] iou_q, sh_q, dis_q;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   bss_front #(.COORD_BITS(C)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .ref_x    (req_ref_x),
      .ref_y    (req_ref_y),
      .ref_w    (req_ref_w),
      .ref_h    (req_ref_h),
      .cand_x   (req_cand_x),
      .cand_y   (req_cand_y),
      .cand_w   (req_cand_w),
      .cand_h   (req_cand_h),
      .ctrl_out (front_ctrl),
      .iou_num  (iou_num),
      .iou_den  (iou_den),
      .sh_num   (sh_num),
      .sh_den   (sh_den),
      .dis_num  (dis_num),
      .dis_den  (dis_den)
   );

   bss_div #(.DATA_W(IOU_W), .QUOT_W(DIV_LAT)) u_div_iou (
      .clock (clock), .en (en), .num (iou_num), .den (iou_den), .quot (iou_q)
   );

   bss_div #(.DATA_W(SH_W), .QUOT_W(DIV_LAT)) u_div_shape (
      .clock (clock), .en (en), .num (sh_num), .den (sh_den), .quot (sh_q)
   );

   bss_div #(.DATA_W(DIS_W), .QUOT_W(DIV_LAT)) u_div_dis (
      .clock (clock), .en (en), .num (dis_num), .den (dis_den), .quot (dis_q)
   );

   // control travels alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) ctrl_ff[i] <= '0;
      end else if (en) begin
         ctrl_ff[0] <= front_ctrl;
         for (int i = 1; i < DIV_LAT; i++) ctrl_ff[i] <= ctrl_ff[i-1];
      end
   end

   bss_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .ctrl_in    (ctrl_ff[DIV_LAT-1]),
      .iou_q      (iou_q),
      .sh_q       (sh_q),
      .dis_q      (dis_q),
      .out_valid  (rsp_valid),
      .score      (rsp_score),
      .degenerate (rsp_degenerate)
   );

   `BSS_CHECK_IMPL(a_deg_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_score == '0)
   `BSS_CHECK_IMPL(a_score_max, clock, reset, rsp_valid, rsp_score <= {1'b1, {FRAC_BITS{1'b0}}})
   `BSS_CHECK_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule

// ===== sim/bss_checker.sv =====
// Scoreboard for the box similarity pipeline: predicts each score from the
// accepted request and compares it with the response. Needs bss_pkg.
`timescale 1ns / 100ps
module bss_checker import bss_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_ref_x,
   input  logic [COORD_BITS-1:0] req_ref_y,
   input  logic [COORD_BITS-1:0] req_ref_w,
   input  logic [COORD_BITS-1:0] req_ref_h,
   input  logic [COORD_BITS-1:0] req_cand_x,
   input  logic [COORD_BITS-1:0] req_cand_y,
   input  logic [COORD_BITS-1:0] req_cand_w,
   input  logic [COORD_BITS-1:0] req_cand_h,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [FRAC_BITS:0]    rsp_score,
   input  logic                  rsp_degenerate,
   output int                    fail_count,
   output int                    pending
);

   localparam int EXP_DEPTH = 64;

   typedef struct {
      logic [FRAC_BITS:0] score;
      logic               degenerate;
   } score_type;

   // expected responses, in request order
   score_type exp_mem [EXP_DEPTH];
   int        wr_cnt = 0;
   int        rd_cnt = 0;

   function automatic logic [63:0] mx(logic [63:0] a, logic [63:0] b);
      return a > b ? a : b;
   endfunction
   function automatic logic [63:0] mn(logic [63:0] a, logic [63:0] b);
      return a < b ? a : b;
   endfunction
   function automatic logic [63:0] df(logic [63:0] a, logic [63:0] b);
      return a > b ? a - b : b - a;
   endfunction

   // floor(2^F * num / den), den > 0
   function automatic logic [63:0] ratio_q(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      if (den == 0) return 0;
      q = (num << FRAC_BITS) / den;
      return q[63:0];
   endfunction

   function automatic score_type predict_score(
      logic [63:0] x1, logic [63:0] y1, logic [63:0] w1, logic [63:0] h1,
      logic [63:0] x2, logic [63:0] y2, logic [63:0] w2, logic [63:0] h2);
      logic [63:0] xe1, ye1, xe2, ye2, bw, bh, ox, oy, inter, uni;
      logic [63:0] iou, shp, dis, dcx, dcy, one, s;
      logic [127:0] num, den;
      score_type r;
      one = 64'd1 << FRAC_BITS;
      xe1 = x1 + w1; ye1 = y1 + h1; xe2 = x2 + w2; ye2 = y2 + h2;
      bw = mx(xe1, xe2) - mn(x1, x2);
      bh = mx(ye1, ye2) - mn(y1, y2);
      if (bw == 0 || bh == 0) begin
         r.score = 0;
         r.degenerate = 1;
         return r;
      end
      ox = mn(xe1, xe2) > mx(x1, x2) ? mn(xe1, xe2) - mx(x1, x2) : 0;
      oy = mn(ye1, ye2) > mx(y1, y2) ? mn(ye1, ye2) - mx(y1, y2) : 0;
      inter = ox * oy;
      uni = w1 * h1 + w2 * h2 - inter;
      iou = (inter > 0 && uni > 0) ? ratio_q(inter, uni) : 0;
      num = 128'(df(w1, w2) * bh) * 128'(df(w1, w2) * bh)
          + 128'(df(h1, h2) * bw) * 128'(df(h1, h2) * bw);
      den = 2 * (128'(bw * bh) * 128'(bw * bh));
      shp = one - ratio_q(num, den);
      dcx = df(x1 + xe1, x2 + xe2);
      dcy = df(y1 + ye1, y2 + ye2);
      num = 128'(dcx) * dcx + 128'(dcy) * dcy;
      den = 4 * 128'(bw * bw + bh * bh);
      dis = one - ratio_q(num, den);
      s = (IOU_WEIGHT * iou + SHAPE_WEIGHT * shp + DIS_WEIGHT * dis) / 10;
      r.score = s[FRAC_BITS:0];
      r.degenerate = 0;
      return r;
   endfunction

   assign pending = wr_cnt - rd_cnt;

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            exp_mem[wr_cnt % EXP_DEPTH] = predict_score(req_ref_x, req_ref_y, req_ref_w,
               req_ref_h, req_cand_x, req_cand_y, req_cand_w, req_cand_h);
            wr_cnt = wr_cnt + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (wr_cnt == rd_cnt) begin
               $display("%0t: unexpected response score %0d degenerate %0b",
                  $time, rsp_score, rsp_degenerate);
               fail_count <= fail_count + 1;
            end else begin
               want   = exp_mem[rd_cnt % EXP_DEPTH];
               rd_cnt = rd_cnt + 1;
               if (want.score !== rsp_score || want.degenerate !== rsp_degenerate) begin
                  $display("%0t: expected score %0d degenerate %0b, got %0d %0b",
                     $time, want.score, want.degenerate, rsp_score, rsp_degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Top of the box similarity testbench: clock, reset, request stimulus, response
// back-pressure and verdict. Needs box_similarity_score, bss_checker and bss_pkg.
`timescale 1ns / 100ps
module tb_top;

   localparam int CB = 12;
   localparam int FB = 16;
   localparam int WATCHDOG = 20000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0, req_ready;
   logic [CB-1:0] req_ref_x = 0, req_ref_y = 0, req_ref_w = 0, req_ref_h = 0;
   logic [CB-1:0] req_cand_x = 0, req_cand_y = 0, req_cand_w = 0, req_cand_h = 0;
   logic          rsp_valid, rsp_ready = 0;
   logic [FB:0]   rsp_score;
   logic          rsp_degenerate;
   int            fail_count, pending;
   int            idle_cycles = 0;

   box_similarity_score #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (.*);

   bss_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_check (.*);

   initial forever #2 clock = ~clock;

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   function automatic logic [CB-1:0] coord(bit wide);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return '1;
         2: return CB'($urandom_range(0, 15));
         default: return wide ? CB'($urandom) : CB'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send(input logic [CB-1:0] rx, ry, rw, rh, cx, cy, cw, ch);
      req_valid  <= 1;
      req_ref_x  <= rx; req_ref_y <= ry; req_ref_w <= rw; req_ref_h <= rh;
      req_cand_x <= cx; req_cand_y <= cy; req_cand_w <= cw; req_cand_h <= ch;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // response back-pressure, long stall now and then, quiet stretches too
   initial begin
      int n;
      @(negedge reset);
      forever begin
         rsp_ready <= 1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      logic [CB-1:0] x, y, w, h;
      int k;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: degenerate, extremes, identical, disjoint, nested, zero area
      send(0, 0, 0, 0, 0, 0, 0, 0);
      send(5, 5, 0, 7, 5, 9, 0, 3);
      send(5, 5, 7, 0, 9, 5, 3, 0);
      send('1, '1, '1, '1, '1, '1, '1, '1);
      send(0, 0, '1, '1, 0, 0, '1, '1);
      send(0, 0, '1, '1, '1, '1, '1, '1);
      send(10, 20, 30, 40, 10, 20, 30, 40);
      send(0, 0, 10, 10, 100, 100, 10, 10);
      send(0, 0, 10, 10, 10, 10, 10, 10);
      send(0, 0, 100, 100, 25, 25, 50, 50);
      send(0, 0, 0, 0, 3, 3, 0, 0);
      send(0, 0, 0, 9, 3, 3, 7, 0);
      send(3, 4, 1, 1, 3, 4, 1, 1);
      send('1, 0, 0, '1, 0, '1, '1, 0);
      send(12'haaa, 12'h555, 12'h555, 12'haaa, 12'h555, 12'haaa, 12'haaa, 12'h555);
      for (k = 0; k < 700; k++) begin
         pause(($urandom_range(0, 3) == 0) ? gap_len() : 0);
         if ($urandom_range(0, 2) != 0) begin
            // overlapping pair: candidate jittered around reference
            x = coord(1); y = coord(1); w = coord(0); h = coord(0);
            send(x, y, w, h, CB'(x + $urandom_range(0, 40) - 20),
               CB'(y + $urandom_range(0, 40) - 20),
               CB'(w + $urandom_range(0, 30) - 15), CB'(h + $urandom_range(0, 30) - 15));
         end else
            send(coord(1), coord(1), coord(1), coord(1),
               coord(1), coord(1), coord(1), coord(1));
      end
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
